FILE: rtl/core/pvs_pkg.sv
// Package for the paletted voxel store: sizes, request/response words and
// the command/status structs between controller and datapath. No dependencies.
package pvs_pkg;

   localparam int EDGE        = 32;
   localparam int CW          = $clog2(EDGE);
   localparam int EW          = CW + 1;
   localparam int VOXELS      = EDGE * EDGE * EDGE;
   localparam int VAW         = $clog2(VOXELS);
   localparam int PAL_ENTRIES = 4096;
   localparam int PAW         = $clog2(PAL_ENTRIES);
   localparam int PCW         = PAW + 1;

   localparam logic [1:0] ACT_GET  = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_BOX  = 2'd2;
   localparam logic [1:0] ACT_UNI  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  x_start;
      logic [4:0]  y_start;
      logic [4:0]  z_start;
      logic [5:0]  x_end;
      logic [5:0]  y_end;
      logic [5:0]  z_end;
      logic [15:0] block_value;
   } req_type;

   typedef struct packed {
      logic [15:0] read_value;
      logic        changed;
      logic [12:0] pal_count;
      logic [4:0]  index_bits;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic make_uni;
      logic srch_rd;
      logic srch_next;
      logic found;
      logic intern;
      logic set_full;
      logic vox_rd;
      logic vox_wr_cmp;
      logic walk_next;
      logic get_rd_pal;
      logic get_cap_uni;
      logic get_cap;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic in_range;
      logic uni_same;
      logic whole;
      logic box_empty;
      logic hit;
      logic srch_last;
      logic pal_full;
      logic walk_last;
      logic clr_last;
      logic width_zero;
      logic rsp_free;
   } stat_type;

   // index width needed for a palette of n entries
   function automatic logic [4:0] width_for(input logic [PCW-1:0] n);
      logic [4:0] w;
      if (n <= PCW'(1))        w = 5'd0;
      else if (n <= PCW'(2))   w = 5'd1;
      else if (n <= PCW'(4))   w = 5'd2;
      else if (n <= PCW'(16))  w = 5'd4;
      else if (n <= PCW'(256)) w = 5'd8;
      else                     w = 5'd16;
      return w;
   endfunction

endpackage

FILE: rtl/core/pvs_ctrl.sv
// Sequencer for the paletted voxel store: walks each word through search,
// intern, voxel read-modify-write, clearing and get reads. Depends on pvs_pkg.
module pvs_ctrl import pvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] ST_CLR_RST = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DECODE  = 4'd2;
   localparam logic [3:0] ST_UNI     = 4'd3;
   localparam logic [3:0] ST_CLR_OP  = 4'd4;
   localparam logic [3:0] ST_SRCH_RD = 4'd5;
   localparam logic [3:0] ST_SRCH_CM = 4'd6;
   localparam logic [3:0] ST_ACT     = 4'd7;
   localparam logic [3:0] ST_VRD     = 4'd8;
   localparam logic [3:0] ST_VCMP    = 4'd9;
   localparam logic [3:0] ST_GET_V   = 4'd10;
   localparam logic [3:0] ST_GET_P   = 4'd11;
   localparam logic [3:0] ST_DONE    = 4'd12;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLR_RST: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.action)
               ACT_GET: begin
                  if (!stat.in_range) state_in = ST_DONE;
                  else if (stat.width_zero) begin
                     cmd.get_cap_uni = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     cmd.vox_rd = 1'b1;
                     state_in = ST_GET_V;
                  end
               end
               ACT_SET: begin
                  if (!stat.in_range || stat.uni_same) state_in = ST_DONE;
                  else begin
                     cmd.srch_rd = 1'b1;
                     state_in = ST_SRCH_CM;
                  end
               end
               ACT_BOX: begin
                  if (stat.whole) state_in = ST_UNI;
                  else begin
                     cmd.srch_rd = 1'b1;
                     state_in = ST_SRCH_CM;
                  end
               end
               default: state_in = ST_UNI;
            endcase
         end
         ST_UNI: begin
            cmd.make_uni = 1'b1;
            // a uniform chunk already has a clear index store
            state_in = stat.width_zero ? ST_DONE : ST_CLR_OP;
         end
         ST_CLR_OP: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_DONE;
         end
         ST_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in = ST_SRCH_CM;
         end
         ST_SRCH_CM: begin
            priority if (stat.hit) begin
               cmd.found = 1'b1;
               state_in = ST_ACT;
            end else if (!stat.srch_last) begin
               cmd.srch_next = 1'b1;
               state_in = ST_SRCH_RD;
            end else if (stat.pal_full) begin
               cmd.set_full = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.intern = 1'b1;
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if (stat.action == ACT_BOX && stat.box_empty) state_in = ST_DONE;
            else begin
               cmd.vox_rd = 1'b1;
               state_in = ST_VCMP;
            end
         end
         ST_VRD: begin
            cmd.vox_rd = 1'b1;
            state_in = ST_VCMP;
         end
         ST_VCMP: begin
            cmd.vox_wr_cmp = 1'b1;
            if (stat.action == ACT_SET || stat.walk_last) state_in = ST_DONE;
            else begin
               cmd.walk_next = 1'b1;
               state_in = ST_VRD;
            end
         end
         ST_GET_V: begin
            cmd.get_rd_pal = 1'b1;
            state_in = ST_GET_P;
         end
         ST_GET_P: begin
            cmd.get_cap = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLR_RST;
      else       state_ff <= state_in;
   end

endmodule

FILE: rtl/core/pvs_dp.sv
// Datapath of the paletted voxel store: palette and index memories, search
// and walk counters, result register. Depends on pvs_pkg.
module pvs_dp import pvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic [15:0]    pal_mem [PAL_ENTRIES];
   logic [PAW-1:0] vox_mem [VOXELS];

   req_type        req_ff, req_in;
   logic [EW-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [PCW-1:0] srch_ff, srch_in;
   logic [PAW-1:0] slot_ff, slot_in;
   logic [15:0]    pal0_ff, pal0_in;
   logic [PCW-1:0] count_ff, count_in;
   logic [4:0]     width_ff, width_in;
   logic [VAW-1:0] clr_ff, clr_in;
   logic [15:0]    rd_ff, rd_in;
   logic           chg_ff, chg_in, full_ff, full_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [15:0]    pal_q_ff;
   logic [PAW-1:0] vox_q_ff;

   logic [EW-1:0]  xe_c, ye_c, ze_c, xs_e, ys_e, zs_e;
   logic [VAW-1:0] walk_addr;
   logic [15:0]    srch_data;
   logic           vox_diff;
   logic [PCW-1:0] count_inc;

   // clamped box and current voxel address
   always_comb begin
      xs_e = EW'(req_ff.x_start);
      ys_e = EW'(req_ff.y_start);
      zs_e = EW'(req_ff.z_start);
      xe_c = (req_ff.x_end > EW'(EDGE)) ? EW'(EDGE) : req_ff.x_end;
      ye_c = (req_ff.y_end > EW'(EDGE)) ? EW'(EDGE) : req_ff.y_end;
      ze_c = (req_ff.z_end > EW'(EDGE)) ? EW'(EDGE) : req_ff.z_end;
      walk_addr = VAW'((int'(cy_ff) * EDGE + int'(cz_ff)) * EDGE + int'(cx_ff));
      srch_data = (srch_ff == '0) ? pal0_ff : pal_q_ff;
      vox_diff  = vox_q_ff != slot_ff;
      count_inc = count_ff + PCW'(1);
   end

   // status to the sequencer
   always_comb begin
      stat.action     = req_ff.action;
      stat.in_range   = (xs_e < EW'(EDGE)) && (ys_e < EW'(EDGE)) && (zs_e < EW'(EDGE));
      stat.uni_same   = (width_ff == 5'd0) && (pal0_ff == req_ff.block_value);
      stat.whole      = (xs_e == '0) && (ys_e == '0) && (zs_e == '0) &&
                        (xe_c == EW'(EDGE)) && (ye_c == EW'(EDGE)) && (ze_c == EW'(EDGE));
      stat.box_empty  = (xs_e >= xe_c) || (ys_e >= ye_c) || (zs_e >= ze_c);
      stat.hit        = srch_data == req_ff.block_value;
      stat.srch_last  = srch_ff == (count_ff - PCW'(1));
      stat.pal_full   = count_ff >= PCW'(PAL_ENTRIES);
      stat.walk_last  = (cx_ff == xe_c - EW'(1)) && (cz_ff == ze_c - EW'(1)) &&
                        (cy_ff == ye_c - EW'(1));
      stat.clr_last   = clr_ff == VAW'(VOXELS - 1);
      stat.width_zero = width_ff == 5'd0;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // next values
   always_comb begin
      req_in = req_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      srch_in = srch_ff; slot_in = slot_ff; pal0_in = pal0_ff;
      count_in = count_ff; width_in = width_ff; clr_in = clr_ff;
      rd_in = rd_ff; chg_in = chg_ff; full_in = full_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         req_in  = req_data;
         cx_in   = EW'(req_data.x_start);
         cy_in   = EW'(req_data.y_start);
         cz_in   = EW'(req_data.z_start);
         srch_in = '0;
         rd_in   = '0;
         chg_in  = 1'b0;
         full_in = 1'b0;
      end
      if (cmd.clr_step) clr_in = clr_ff + VAW'(1);
      if (cmd.make_uni) begin
         chg_in   = !stat.uni_same;
         pal0_in  = req_ff.block_value;
         count_in = PCW'(1);
         width_in = 5'd0;
         clr_in   = '0;
      end
      if (cmd.srch_next) srch_in = srch_ff + PCW'(1);
      if (cmd.found) slot_in = srch_ff[PAW-1:0];
      if (cmd.intern) begin
         slot_in  = count_ff[PAW-1:0];
         count_in = count_inc;
         if (width_for(count_inc) > width_ff) width_in = width_for(count_inc);
      end
      if (cmd.set_full) full_in = 1'b1;
      if (cmd.vox_wr_cmp && vox_diff) chg_in = 1'b1;
      // walk order: x fastest, then z, then y
      if (cmd.walk_next) begin
         if (cx_ff + EW'(1) < xe_c) cx_in = cx_ff + EW'(1);
         else begin
            cx_in = xs_e;
            if (cz_ff + EW'(1) < ze_c) cz_in = cz_ff + EW'(1);
            else begin
               cz_in = zs_e;
               cy_in = cy_ff + EW'(1);
            end
         end
      end
      if (cmd.get_cap_uni) rd_in = pal0_ff;
      if (cmd.get_cap) begin
         if (PCW'(vox_q_ff) < count_ff)
            rd_in = (vox_q_ff == '0) ? pal0_ff : pal_q_ff;
         else
            rd_in = '0;
      end
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.read_value    = rd_ff;
         rsp_in.changed       = chg_ff;
         rsp_in.pal_count     = 13'(count_ff);
         rsp_in.index_bits    = width_ff;
         rsp_in.status        = full_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pal0_ff      <= '0;
         count_ff     <= PCW'(1);
         width_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pal0_ff      <= pal0_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      srch_ff <= srch_in;
      slot_ff <= slot_in;
      rd_ff   <= rd_in;
      chg_ff  <= chg_in;
      full_ff <= full_in;
      rsp_ff  <= rsp_in;
   end

   // palette memory, entry zero lives in pal0_ff
   always_ff @(posedge clock) begin
      if (cmd.intern) pal_mem[count_ff[PAW-1:0]] <= req_ff.block_value;
      if (cmd.srch_rd) pal_q_ff <= pal_mem[srch_ff[PAW-1:0]];
      else if (cmd.get_rd_pal) pal_q_ff <= pal_mem[vox_q_ff];
   end

   // index memory
   always_ff @(posedge clock) begin
      if (cmd.clr_step) vox_mem[clr_ff] <= '0;
      else if (cmd.vox_wr_cmp && vox_diff) vox_mem[walk_addr] <= slot_ff;
      if (cmd.vox_rd) vox_q_ff <= vox_mem[walk_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0) else $error("palette count is zero");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PCW'(PAL_ENTRIES)) else $error("palette count overflow");
   a_width_track: assert property (@(posedge clock) disable iff (reset)
      width_ff == width_for(count_ff)) else $error("index width out of step");
   a_intern_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.intern |=> count_ff == $past(count_ff) + PCW'(1))
      else $error("intern did not grow palette");
`endif

endmodule

FILE: rtl/core/paletted_voxel_store.sv
// Paletted voxel store: 32-cube chunk of 16-bit block ids held as a palette
// plus a per-voxel index. Sequencer plus datapath. Depends on pvs_pkg.
//
// One word is taken at a time. After reset the index store is cleared
// before the first word is taken. A get on a uniform chunk reads neither
// memory. Set and fill box search the palette serially from its single
// read port, reading and then comparing each entry; an id not found is
// interned after the last entry, or refused when the palette is full.
// A set or box fill then reads each voxel and writes it back if it
// differs, through the one index memory port; an empty box writes no
// voxel. A uniform fill, or a box covering the chunk, sweeps the index
// store once on a chunk that is not uniform. The result sits in an
// output register, so one result may wait while the next word is
// worked on.
module paletted_voxel_store import pvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   pvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pvs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/paletted_voxel_store_tb.sv
`timescale 1ns / 100ps
// Testbench for paletted_voxel_store: a directed table, then random gets, sets and fills,
// checked word by word against table values or an in-bench palette/voxel predictor.
// Depends on pvs_pkg and the paletted_voxel_store RTL.
module paletted_voxel_store_tb;
   import pvs_pkg::*;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor state
   logic [15:0] pal_ids [PAL_ENTRIES];
   int          pal_n;
   int          idx_w;
   logic [11:0] vox_idx [VOXELS];

   rsp_type       expected_q [$];
   rsp_type       want;
   int            errors = 0;
   int            results_seen = 0;
   int            tx_pct = 0;
   int            rx_pct = 0;
   int            hold_left = 0;
   bit            held_once = 0;
   logic [15:0]   id_pool [24];
   table_row_type rows [16];

   paletted_voxel_store dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   function automatic int bits_for(input int n);
      if (n <= 1) return 0;
      if (n <= 2) return 1;
      if (n <= 4) return 2;
      if (n <= 16) return 4;
      if (n <= 256) return 8;
      return 16;
   endfunction

   function automatic void store_clear();
      pal_n = 1;
      idx_w = 0;
      foreach (vox_idx[i]) vox_idx[i] = '0;
   endfunction

   // find or add an id; 0 when the palette is full
   function automatic bit pal_lookup(input logic [15:0] id, output int slot);
      int w;
      slot = 0;
      for (int i = 0; i < pal_n; i++)
         if (pal_ids[i] == id) begin
            slot = i;
            return 1'b1;
         end
      if (pal_n >= PAL_ENTRIES) return 1'b0;
      pal_ids[pal_n] = id;
      slot = pal_n;
      pal_n++;
      w = bits_for(pal_n);
      if (w > idx_w) idx_w = w;
      return 1'b1;
   endfunction

   function automatic bit go_uniform(input logic [15:0] id);
      bit same;
      same = (idx_w == 0) && (pal_ids[0] == id);
      pal_ids[0] = id;
      store_clear();
      return !same;
   endfunction

   function automatic rsp_type voxel_predict(input req_type r);
      rsp_type o;
      int      slot;
      int      xe, ye, ze;
      int      a;
      o = '0;
      unique case (r.action)
         ACT_GET: begin
            if (idx_w == 0) o.read_value = pal_ids[0];
            else begin
               slot = int'(vox_idx[{r.y_start, r.z_start, r.x_start}]);
               o.read_value = (slot < pal_n) ? pal_ids[slot] : 16'h0;
            end
         end
         ACT_SET: begin
            if (!(idx_w == 0 && pal_ids[0] == r.block_value)) begin
               if (!pal_lookup(r.block_value, slot)) o.status = 1'b1;
               else begin
                  a = int'({r.y_start, r.z_start, r.x_start});
                  if (int'(vox_idx[a]) != slot) begin
                     vox_idx[a] = 12'(slot);
                     o.changed = 1'b1;
                  end
               end
            end
         end
         ACT_BOX: begin
            xe = (r.x_end > EDGE) ? EDGE : int'(r.x_end);
            ye = (r.y_end > EDGE) ? EDGE : int'(r.y_end);
            ze = (r.z_end > EDGE) ? EDGE : int'(r.z_end);
            if (r.x_start == 0 && r.y_start == 0 && r.z_start == 0 &&
                xe == EDGE && ye == EDGE && ze == EDGE)
               o.changed = go_uniform(r.block_value);
            else if (!pal_lookup(r.block_value, slot)) o.status = 1'b1;
            else
               for (int y = int'(r.y_start); y < ye; y++)
                  for (int z = int'(r.z_start); z < ze; z++)
                     for (int x = int'(r.x_start); x < xe; x++) begin
                        a = y * EDGE * EDGE + z * EDGE + x;
                        if (int'(vox_idx[a]) != slot) begin
                           vox_idx[a] = 12'(slot);
                           o.changed = 1'b1;
                        end
                     end
         end
         default: o.changed = go_uniform(r.block_value);
      endcase
      o.pal_count  = pal_n[12:0];
      o.index_bits = idx_w[4:0];
      return o;
   endfunction

   function automatic req_type mk(input logic [1:0] act, input int xs, ys, zs, xe, ye, ze,
                                  input logic [15:0] v);
      req_type r;
      r.action = act;
      r.x_start = 5'(xs); r.y_start = 5'(ys); r.z_start = 5'(zs);
      r.x_end = 6'(xe); r.y_end = 6'(ye); r.z_end = 6'(ze);
      r.block_value = v;
      return r;
   endfunction

   function automatic rsp_type mkr(input logic [15:0] rv, input bit ch, input int ps, ib);
      rsp_type o;
      o.read_value = rv; o.changed = ch; o.pal_count = 13'(ps); o.index_bits = 5'(ib);
      o.status = 1'b0;
      return o;
   endfunction

   // one box edge: mostly small, sometimes clamped or empty
   function automatic void box_edge(output logic [4:0] s, output logic [5:0] e);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         s = 5'($urandom_range(29, 31));
         e = 6'($urandom_range(32, 63));
      end else if (pick == 1) begin
         s = 5'($urandom_range(0, 31));
         e = 6'($urandom_range(0, s));
      end else begin
         s = 5'($urandom_range(0, 31));
         e = 6'(s) + 6'($urandom_range(0, 3));
      end
   endfunction

   function automatic req_type random_word();
      req_type r;
      int      p;
      r = '0;
      r.x_start = 5'($urandom); r.y_start = 5'($urandom); r.z_start = 5'($urandom);
      r.x_end = 6'($urandom); r.y_end = 6'($urandom); r.z_end = 6'($urandom);
      r.block_value = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : id_pool[$urandom_range(0, 23)];
      p = $urandom_range(0, 99);
      if (p < 25) r.action = ACT_GET;
      else if (p < 74) r.action = ACT_SET;
      else if (p < 99) begin
         r.action = ACT_BOX;
         box_edge(r.x_start, r.x_end);
         box_edge(r.y_start, r.y_end);
         box_edge(r.z_start, r.z_end);
      end else r.action = ACT_UNI;
      return r;
   endfunction

   // offer one word, called and returning at a rising edge
   task automatic offer(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type p;
      if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(negedge clock); while (!req_ready);
      p = voxel_predict(r);
      expected_q.insert(expected_q.size(), typed ? typed_rsp : p);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!held_once && results_seen == 150) begin
         held_once <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else rsp_ready <= (rx_pct == 0) || ($urandom_range(0, 99) >= rx_pct);
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", rsp_data);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.read_value !== want.read_value || rsp_data.changed !== want.changed ||
                rsp_data.pal_count !== want.pal_count ||
                rsp_data.index_bits !== want.index_bits || rsp_data.status !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected rd=%h chg=%b pal=%0d bits=%0d st=%b,",
                           want.read_value, want.changed, want.pal_count, want.index_bits,
                           want.status, " got rd=%h chg=%b pal=%0d bits=%0d st=%b",
                           rsp_data.read_value, rsp_data.changed,
                           rsp_data.pal_count, rsp_data.index_bits, rsp_data.status);
            end
         end
      end
   end

   initial begin
      foreach (pal_ids[i]) pal_ids[i] = '0;
      store_clear();
      foreach (id_pool[i]) id_pool[i] = 16'($urandom);
      rows[0]  = '{mk(ACT_GET, 0, 0, 0, 0, 0, 0, 16'h0), 1'b1, mkr(16'h0, 1'b0, 1, 0)};
      rows[1]  = '{mk(ACT_SET, 31, 31, 31, 0, 0, 0, 16'h0), 1'b1, mkr(16'h0, 1'b0, 1, 0)};
      rows[2]  = '{mk(ACT_SET, 31, 31, 31, 0, 0, 0, 16'hFFFF), 1'b1,
                   mkr(16'h0, 1'b1, 2, 1)};
      rows[3]  = '{mk(ACT_GET, 31, 31, 31, 63, 63, 63, 16'h0), 1'b1,
                   mkr(16'hFFFF, 1'b0, 2, 1)};
      rows[4]  = '{mk(ACT_GET, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1, mkr(16'h0, 1'b0, 2, 1)};
      // empty box still interns its id
      rows[5]  = '{mk(ACT_BOX, 5, 5, 5, 5, 5, 5, 16'h1234), 1'b1, mkr(16'h0, 1'b0, 3, 2)};
      rows[6]  = '{mk(ACT_BOX, 30, 0, 31, 63, 2, 40, 16'hABCD), 1'b0, '0};
      rows[7]  = '{mk(ACT_SET, 1, 2, 3, 0, 0, 0, 16'h1234), 1'b0, '0};
      rows[8]  = '{mk(ACT_GET, 1, 2, 3, 0, 0, 0, 16'h0), 1'b1, mkr(16'h1234, 1'b0, 4, 2)};
      // box over the whole chunk acts as a uniform fill
      rows[9]  = '{mk(ACT_BOX, 0, 0, 0, 63, 63, 63, 16'h7), 1'b1, mkr(16'h0, 1'b1, 1, 0)};
      rows[10] = '{mk(ACT_UNI, 0, 0, 0, 0, 0, 0, 16'h7), 1'b1, mkr(16'h0, 1'b0, 1, 0)};
      rows[11] = '{mk(ACT_GET, 17, 9, 30, 0, 0, 0, 16'h0), 1'b1, mkr(16'h7, 1'b0, 1, 0)};
      rows[12] = '{mk(ACT_UNI, 31, 31, 31, 63, 63, 63, 16'h0), 1'b1,
                   mkr(16'h0, 1'b1, 1, 0)};
      rows[13] = '{mk(ACT_BOX, 0, 0, 0, 32, 32, 32, 16'h0), 1'b1, mkr(16'h0, 1'b0, 1, 0)};
      rows[14] = '{mk(ACT_SET, 0, 0, 0, 0, 0, 0, 16'h5), 1'b1, mkr(16'h0, 1'b1, 2, 1)};
      rows[15] = '{mk(ACT_BOX, 0, 0, 0, 32, 32, 32, 16'h5), 1'b1, mkr(16'h0, 1'b1, 1, 0)};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) offer(rows[i].cmd, rows[i].typed, rows[i].want);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         tx_pct = (ph == 1) ? 51 : (ph == 3) ? 21 : 0;
         rx_pct = (ph == 2) ? 51 : (ph == 3) ? 21 : 0;
         // grow the palette past 256 entries once, widening to 16-bit indices
         if (ph == 1)
            for (int k = 0; k < 300; k++)
               offer(mk(ACT_SET, $urandom, $urandom, $urandom, 0, 0, 0, 16'(16'h1000 + k)),
                     1'b0, '0);
         for (int k = 0; k < 125; k++) offer(random_word(), 1'b0, '0);
         // pause until every expected word is back
         drain();
         @(posedge clock);
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
